### sv/jlss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlss_pkg
// Shared constants and types of the jerk-limited safe-stop block.
// ----------------------------------------------------------------------------
package jlss_pkg;

  // Fixed-point format of all time, velocity and distance values.
  localparam int FRAC_BITS = 16;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_SCALE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_JERK_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DECEL_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REACTION_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_MARGIN  = 3'd4;

  // Braking regime codes.
  localparam logic [1:0] REGIME_DELAY = 2'd0;
  localparam logic [1:0] REGIME_RAMP  = 2'd1;
  localparam logic [1:0] REGIME_DECEL = 2'd2;

  // Saturation level of wide intermediates.
  localparam logic [62:0] SAT_CAP = 63'h4000_0000_0000_0000;
  // Velocities at or above this level drive every nonzero product term to
  // output saturation, so they are held there.
  localparam logic [48:0] VEL_CAP = 49'h1_0000_0000_0000;
  // Distance terms are held at 2^31; any of them there saturates the output.
  localparam logic [31:0] DIST_CAP = 32'h8000_0000;
  localparam logic [30:0] OUT_MAX  = 31'h7FFF_FFFF;

  // Division by six as a reciprocal multiply: dividends are held at six
  // times 2^31, and the quotient is the product shifted down by 37.
  localparam logic [34:0] SIX_CAP   = 35'h3_0000_0000;
  localparam logic [34:0] RECIP_SIX = 35'd22906492246;   // ceil(2^37 / 6)

  // One classified transaction waiting for the arithmetic pipeline.
  typedef struct packed {
    logic [1:0]  regime;
    logic [23:0] span;     // ramp time for the ramp, decel time for decel
  } entry_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [23:0] t1;       // reaction delay
    logic [27:0] margin;   // distance margin
    logic [25:0] jm;       // scaled jerk magnitude
    logic [25:0] am;       // scaled decel magnitude
    logic [24:0] t2c;      // ramp time, held at 2^24
    logic [48:0] v2;       // velocity gained over the whole ramp, held at VEL_CAP
    logic [31:0] d2;       // jerk distance over the whole ramp, held at DIST_CAP
  } derived_t;

endpackage

### sv/jlss_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlss_cfg
// Configuration registers and a sequencer that derives the ramp constants
// with a shared bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
module jlss_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jlss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jlss_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            busy,
  output jlss_pkg::derived_t              derived
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCALE = 8'b0000_0010,
    ST_T2    = 8'b0000_0100,
    ST_SQ    = 8'b0000_1000,
    ST_V2    = 8'b0001_0000,
    ST_CUBE  = 8'b0010_0000,
    ST_JW    = 8'b0100_0000,
    ST_SIX   = 8'b1000_0000
  } seq_state_t;

  localparam int          F       = jlss_pkg::FRAC_BITS;
  localparam logic [5:0]  CNT_END = 6'd63;

  // Configuration registers.
  logic [17:0] brake_scale;
  logic [23:0] stop_jerk_limit;
  logic [23:0] stop_decel_limit;
  logic [23:0] reaction_delay;
  logic [27:0] distance_margin;

  seq_state_t  state;
  logic        go;
  logic [5:0]  cnt;

  // Serial engines.
  logic [62:0]  ma, mb;
  logic [125:0] mp;
  logic         mzero, msat;
  logic [62:0]  dq;
  logic [25:0]  dr, dd;

  // Derived values.
  logic [25:0] jm, am;
  logic [62:0] t2, s2, w, jw;
  logic [48:0] v2;
  logic [31:0] d2;

  logic [23:0]  jmag, amag;
  logic [41:0]  jprod, aprod;
  logic [62:0]  op_a, op_b;
  logic [62:0]  mul_res, half_res;
  logic [63:0]  mul_top;
  logic [26:0]  div_rs;
  logic         div_bit;
  logic [62:0]  t2_numer;
  logic [34:0]  six_arg;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // Magnitudes of the negative limits, scaled by the safety ratio.
  always_comb begin
    jmag  = stop_jerk_limit[23] ? 24'(25'h100_0000 - {1'b0, stop_jerk_limit}) : 24'd0;
    amag  = stop_decel_limit[23] ? 24'(25'h100_0000 - {1'b0, stop_decel_limit}) : 24'd0;
    jprod = 42'(brake_scale) * 42'(jmag) + 42'(1 << (F - 1));
    aprod = 42'(brake_scale) * 42'(amag) + 42'(1 << (F - 1));
  end

  // Multiplier operands for each step. The division of the ramp cube by six
  // runs as a multiply by the reciprocal, with the dividend held at six
  // times 2^31 so that the quotient lands on DIST_CAP when it saturates.
  always_comb begin
    six_arg = ((jw >= 63'(jlss_pkg::SIX_CAP)) ? jlss_pkg::SIX_CAP : jw[34:0]) + 35'd3;
    case (state)
      ST_SQ:   begin op_a = t2;           op_b = t2; end
      ST_V2:   begin op_a = 63'(jm);      op_b = s2; end
      ST_CUBE: begin op_a = s2;           op_b = t2; end
      ST_JW:   begin op_a = 63'(jm);      op_b = w;  end
      ST_SIX:  begin op_a = 63'(six_arg); op_b = 63'(jlss_pkg::RECIP_SIX); end
      default: begin op_a = '0;           op_b = '0; end
    endcase
  end

  // Rounded, saturating product of the finished multiply.
  always_comb begin
    if (mzero) begin
      mul_res = '0;
    end else if (msat || (mp > 126'(jlss_pkg::SAT_CAP))) begin
      mul_res = jlss_pkg::SAT_CAP;
    end else begin
      mul_res = 63'((mp + 126'(1 << (F - 1))) >> F);
    end
    half_res = (mul_res >= jlss_pkg::SAT_CAP) ? jlss_pkg::SAT_CAP :
               63'((64'(mul_res) + 64'd1) >> 1);
  end

  // One step of each serial engine.
  always_comb begin
    mul_top  = {1'b0, mp[125:63]} + (mb[0] ? {1'b0, ma} : 64'd0);
    div_rs   = {dr, dq[62]};
    div_bit  = (div_rs >= {1'b0, dd});
    t2_numer = 63'({am, 16'd0}) + 63'(jm >> 1);
  end

  // Register writes and sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      brake_scale      <= 18'd65536;
      stop_jerk_limit  <= 24'hFC_0000;
      stop_decel_limit <= 24'hFC_0000;
      reaction_delay   <= 24'd6554;
      distance_margin  <= 28'd65536;
      state            <= ST_SCALE;
      go               <= 1'b1;
      cnt              <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        jlss_pkg::CFG_BRAKE_SCALE:      brake_scale      <= cfg_data[17:0];
        jlss_pkg::CFG_STOP_JERK_LIMIT:  stop_jerk_limit  <= cfg_data[23:0];
        jlss_pkg::CFG_STOP_DECEL_LIMIT: stop_decel_limit <= cfg_data[23:0];
        jlss_pkg::CFG_REACTION_DELAY:   reaction_delay   <= cfg_data[23:0];
        jlss_pkg::CFG_DISTANCE_MARGIN:  distance_margin  <= cfg_data[27:0];
        default: ;
      endcase
      state <= ST_SCALE;
      go    <= 1'b1;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: ;
        ST_SCALE: begin
          state <= ST_T2;
          go    <= 1'b1;
        end
        default: begin
          if (go) begin
            // A zero jerk skips the ramp-time division.
            if (state == ST_T2 && jm == '0) begin
              state <= ST_SQ;
            end else begin
              go  <= 1'b0;
              cnt <= '0;
            end
          end else if (cnt == CNT_END) begin
            go <= 1'b1;
            case (state)
              ST_T2:   state <= ST_SQ;
              ST_SQ:   state <= ST_V2;
              ST_V2:   state <= ST_CUBE;
              ST_CUBE: state <= ST_JW;
              ST_JW:   state <= ST_SIX;
              default: state <= ST_IDLE;
            endcase
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
      endcase
    end
  end

  // Serial arithmetic and capture of derived values.
  always_ff @(posedge clk) begin
    case (state)
      ST_SCALE: begin
        jm <= jprod[41:16];
        am <= aprod[41:16];
      end
      ST_T2: begin
        if (go) begin
          t2 <= jlss_pkg::SAT_CAP;
          dq <= t2_numer;
          dd <= jm;
          dr <= '0;
        end else if (cnt == CNT_END) begin
          t2 <= dq;
        end else begin
          dr <= div_bit ? 26'(div_rs - {1'b0, dd}) : div_rs[25:0];
          dq <= {dq[61:0], div_bit};
        end
      end
      ST_SQ, ST_V2, ST_CUBE, ST_JW, ST_SIX: begin
        if (go) begin
          ma    <= op_a;
          mb    <= op_b;
          mp    <= '0;
          mzero <= (op_a == '0) || (op_b == '0);
          msat  <= (op_a >= jlss_pkg::SAT_CAP) || (op_b >= jlss_pkg::SAT_CAP);
        end else if (cnt == CNT_END) begin
          case (state)
            ST_SQ:   s2 <= mul_res;
            ST_V2:   v2 <= (half_res >= 63'(jlss_pkg::VEL_CAP)) ? jlss_pkg::VEL_CAP :
                           half_res[48:0];
            ST_CUBE: w  <= mul_res;
            ST_JW:   jw <= mul_res;
            default: d2 <= mp[68:37];
          endcase
        end else begin
          mp <= {mul_top, mp[62:1]};
          mb <= mb >> 1;
        end
      end
      default: ;
    endcase
  end

  // Derived values seen by the datapath.
  always_comb begin
    derived.t1     = reaction_delay;
    derived.margin = distance_margin;
    derived.jm     = jm;
    derived.am     = am;
    derived.t2c    = (t2 >= 63'h100_0000) ? 25'h100_0000 : t2[24:0];
    derived.v2     = v2;
    derived.d2     = d2;
  end

endmodule

### sv/jlss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlss_front
// Accepts time-to-collision transactions and classifies each into its
// braking regime with the time spent in the active phase.
// ----------------------------------------------------------------------------
module jlss_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        time_to_collision,
  input  logic               busy,
  input  logic               q_full,
  input  jlss_pkg::derived_t derived,
  output logic               push,
  output jlss_pkg::entry_t   push_entry
);

  logic [23:0] t;

  assign in_ready = !busy && !q_full;
  assign push     = in_valid && in_ready;

  // Delay, ramp or ramp plus constant deceleration.
  always_comb begin
    t = time_to_collision - derived.t1;
    if (time_to_collision <= derived.t1) begin
      push_entry.regime = jlss_pkg::REGIME_DELAY;
      push_entry.span   = '0;
    end else if ({1'b0, t} <= derived.t2c) begin
      push_entry.regime = jlss_pkg::REGIME_RAMP;
      push_entry.span   = t;
    end else begin
      push_entry.regime = jlss_pkg::REGIME_DECEL;
      push_entry.span   = t - derived.t2c[23:0];
    end
  end

endmodule

### sv/jlss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlss_queue
// Short FIFO between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module jlss_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jlss_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output jlss_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jlss_pkg::entry_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

### sv/jlss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlss_back
// Eight-stage arithmetic pipeline that turns a classified transaction into
// the safe velocity and stopping distance, with an output register.
// ----------------------------------------------------------------------------
module jlss_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  jlss_pkg::entry_t   head,
  output logic               pop,
  input  jlss_pkg::derived_t derived,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] max_velocity,
  output logic signed [31:0] stop_distance,
  output logic [1:0]         regime
);

  localparam int          F     = jlss_pkg::FRAC_BITS;
  localparam logic [34:0] Y6    = jlss_pkg::SIX_CAP;     // six times 2^31
  localparam logic [34:0] RECIP = jlss_pkg::RECIP_SIX;   // ceil(2^37 / 6)

  logic       adv;
  logic [8:1] vld;

  // Stage payloads.
  logic [1:0]  r1, r2, r3, r4, r5, r6, r7, r8;
  logic [23:0] x1, x2, x3;
  logic [47:0] psq1;
  logic [49:0] pmt1;
  logic [31:0] sq2;
  logic [33:0] mt2;
  logic [57:0] pc3;
  logic [55:0] pu3;
  logic [48:0] vr3;
  logic [48:0] v4, bw4;
  logic [25:0] bk4;
  logic [31:0] c4, c5, c6, c7, c8;
  logic [30:0] vo4, vo5, vo6, vo7, vo8;
  logic [48:0] pal5;
  logic [47:0] pah5;
  logic [50:0] pbl5;
  logic [49:0] pbh5;
  logic [72:0] pa6;
  logic [74:0] pb6;
  logic [31:0] ta7, tb7, ta8, tb8;
  logic [34:0] yb7;

  // Combinational helpers.
  logic [25:0] coef2;
  logic [49:0] vsum2;
  logic [41:0] rc3;
  logic [41:0] hp3;
  logic [39:0] ur3;
  logic [48:0] v3;
  logic [56:0] za6;
  logic [58:0] zb6;
  logic [69:0] q7;
  logic [33:0] dsum8;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_empty;

  // Stage valid bits and the output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[7:1], !q_empty};
      out_valid <= vld[8];
    end
  end

  always_comb begin
    coef2 = (r2 == jlss_pkg::REGIME_RAMP) ? derived.jm : derived.am;
    vsum2 = 50'(derived.v2) + 50'(mt2);
    rc3   = 42'((pc3 + 58'(1 << (F - 1))) >> F);
    hp3   = 42'((43'(rc3) + 43'd1) >> 1);
    ur3   = 40'((pu3 + 56'(1 << (F - 1))) >> F);
    case (r3)
      jlss_pkg::REGIME_RAMP:  v3 = 49'(hp3);
      jlss_pkg::REGIME_DECEL: v3 = vr3;
      default:                v3 = '0;
    endcase
    za6   = 57'((pa6 + 73'(1 << (F - 1))) >> F);
    zb6   = 59'((pb6 + 75'(1 << (F - 1))) >> F);
    q7    = 70'(yb7) * 70'(RECIP);
    dsum8 = 34'(ta8) + 34'(tb8) + 34'(c8) + 34'(derived.margin) +
            ((r8 == jlss_pkg::REGIME_DECEL) ? 34'(derived.d2) : 34'd0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Squares of the phase time and decel velocity product.
      r1   <= head.regime;
      x1   <= head.span;
      psq1 <= 48'(head.span) * 48'(head.span);
      pmt1 <= 50'(derived.am) * 50'(head.span);

      // Rounding.
      r2  <= r1;
      x2  <= x1;
      sq2 <= 32'((psq1 + 48'(1 << (F - 1))) >> F);
      mt2 <= 34'((pmt1 + 50'(1 << (F - 1))) >> F);

      // Jerk or decel times the square, cube of the ramp time, decel velocity.
      r3  <= r2;
      x3  <= x2;
      pc3 <= 58'(coef2) * 58'(sq2);
      pu3 <= 56'(sq2) * 56'(x2);
      vr3 <= (vsum2 >= 50'(jlss_pkg::VEL_CAP)) ? jlss_pkg::VEL_CAP : vsum2[48:0];

      // Velocity, constant-decel distance and operands of the second product.
      r4  <= r3;
      v4  <= v3;
      vo4 <= (v3 >= 49'(jlss_pkg::OUT_MAX)) ? jlss_pkg::OUT_MAX : v3[30:0];
      c4  <= (r3 != jlss_pkg::REGIME_DECEL) ? 32'd0 :
             (hp3 >= 42'(jlss_pkg::DIST_CAP)) ? jlss_pkg::DIST_CAP : hp3[31:0];
      case (r3)
        jlss_pkg::REGIME_RAMP: begin
          bw4 <= 49'(ur3);
          bk4 <= derived.jm;
        end
        jlss_pkg::REGIME_DECEL: begin
          bw4 <= derived.v2;
          bk4 <= 26'(x3);
        end
        default: begin
          bw4 <= '0;
          bk4 <= '0;
        end
      endcase

      // Partial products of the two wide multiplies.
      r5   <= r4;
      c5   <= c4;
      vo5  <= vo4;
      pal5 <= 49'(v4[24:0]) * 49'(derived.t1);
      pah5 <= 48'(v4[48:25]) * 48'(derived.t1);
      pbl5 <= 51'(bw4[24:0]) * 51'(bk4);
      pbh5 <= 50'(bw4[48:25]) * 50'(bk4);

      // Partial product sums.
      r6  <= r5;
      c6  <= c5;
      vo6 <= vo5;
      pa6 <= 73'(pal5) + (73'(pah5) << 25);
      pb6 <= 75'(pbl5) + (75'(pbh5) << 25);

      // Rounding and holding of the distance terms.
      r7  <= r6;
      c7  <= c6;
      vo7 <= vo6;
      ta7 <= (za6 >= 57'(jlss_pkg::DIST_CAP)) ? jlss_pkg::DIST_CAP : za6[31:0];
      if (r6 == jlss_pkg::REGIME_RAMP) begin
        yb7 <= ((zb6 >= 59'(Y6)) ? Y6 : zb6[34:0]) + 35'd3;
        tb7 <= '0;
      end else begin
        yb7 <= '0;
        tb7 <= (zb6 >= 59'(jlss_pkg::DIST_CAP)) ? jlss_pkg::DIST_CAP : zb6[31:0];
      end

      // Division of the ramp jerk distance by six.
      r8  <= r7;
      c8  <= c7;
      vo8 <= vo7;
      ta8 <= ta7;
      tb8 <= (r7 == jlss_pkg::REGIME_RAMP) ? q7[68:37] : tb7;

      // Output register.
      regime        <= r8;
      max_velocity  <= signed'({1'b0, vo8});
      stop_distance <= signed'({1'b0, (dsum8 >= 34'(jlss_pkg::OUT_MAX)) ?
                                      jlss_pkg::OUT_MAX : dsum8[30:0]});
    end
  end

endmodule

### sv/jerk_limited_safe_stop_motion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerk_limited_safe_stop_motion_top
// Highest safe velocity and stopping distance for a time to collision under
// a delay, constant-jerk and constant-deceleration braking profile.
// ----------------------------------------------------------------------------
// The block takes one time-to-collision transaction per clock cycle while
// in_ready is high, and passes each through the input queue, the eight
// arithmetic pipeline stages and the output register, in that order; a
// stalled output holds the pipeline. After reset and after every
// configuration write, a sequencer derives the ramp time and the whole-ramp
// velocity and distance with one bit-serial multiplier and divider, during
// which in_ready stays low.
// Configuration writes are always taken.
module jerk_limited_safe_stop_motion_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [23:0]                     time_to_collision,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              max_velocity,
  output logic signed [31:0]              stop_distance,
  output logic [1:0]                      regime,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jlss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jlss_pkg::CFG_DATA_W-1:0] cfg_data
);

  jlss_pkg::derived_t derived;
  jlss_pkg::entry_t   push_entry, head;
  logic               busy, push, pop, q_full, q_empty;

  // Configuration and derived constants.
  jlss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .derived   (derived)
  );

  // Classification of incoming transactions.
  jlss_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .time_to_collision (time_to_collision),
    .busy              (busy),
    .q_full            (q_full),
    .derived           (derived),
    .push              (push),
    .push_entry        (push_entry)
  );

  // Decoupling queue.
  jlss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // Arithmetic pipeline.
  jlss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .head          (head),
    .pop           (pop),
    .derived       (derived),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .max_velocity  (max_velocity),
    .stop_distance (stop_distance),
    .regime        (regime)
  );

endmodule
